/* hdl/cct_pkg.sv */
// Package for the calendar clock tick block: transaction types, calendar state type,
// epoch reset values, month length table and leap year constants.
// No dependencies.
package cct_pkg;

   // Field widths fixed by the calendar format
   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 16;

   // Request modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Rollover limits
   localparam logic [SEC_W:0]   SEC_LIMIT   = 7'd60;
   localparam logic [MIN_W:0]   MIN_LIMIT   = 7'd60;
   localparam logic [HOUR_W:0]  HOUR_LIMIT  = 6'd24;
   localparam logic [WDAY_W:0]  WDAY_LAST   = 4'd7;
   localparam logic [MONTH_W:0] MONTH_LAST  = 5'd12;

   // Month numbers that need special lengths
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

   // Divisibility by 25 through the modular inverse of 25 mod 2^16:
   // y is a multiple of 25 iff (y * INV25) mod 2^16 <= floor((2^16 - 1) / 25)
   localparam logic [YEAR_W-1:0] INV25       = 16'h5C29;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

   // Epoch reset values: 1900-01-01 00:00:00, Monday
   localparam logic [DAY_W-1:0]   EPOCH_DAY   = 5'd1;
   localparam logic [WDAY_W-1:0]  EPOCH_WDAY  = 3'd1;
   localparam logic [MONTH_W-1:0] EPOCH_MONTH = 4'd1;
   localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 16'd1900;
   localparam logic               EPOCH_LEAP  = 1'b0;

   typedef struct packed {
      logic                mode;
      logic [SEC_W-1:0]    set_second;
      logic [MIN_W-1:0]    set_minute;
      logic [HOUR_W-1:0]   set_hour;
      logic [DAY_W-1:0]    set_day;
      logic [WDAY_W-1:0]   set_weekday;
      logic [MONTH_W-1:0]  set_month;
      logic [YEAR_W-1:0]   set_year;
   } req_type;

   typedef struct packed {
      logic [SEC_W-1:0]    cur_second;
      logic [MIN_W-1:0]    cur_minute;
      logic [HOUR_W-1:0]   cur_hour;
      logic [DAY_W-1:0]    cur_day;
      logic [WDAY_W-1:0]   cur_weekday;
      logic [MONTH_W-1:0]  cur_month;
      logic [YEAR_W-1:0]   cur_year;
      logic                is_leap;
   } rsp_type;

   typedef struct packed {
      logic [SEC_W-1:0]    second;
      logic [MIN_W-1:0]    minute;
      logic [HOUR_W-1:0]   hour;
      logic [DAY_W-1:0]    day;
      logic [WDAY_W-1:0]   weekday;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
   } cal_type;

   // Days in a month; months outside January..December count as 31 days
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         MONTH_FEB: days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = DAYS_SHORT;
         default: days = DAYS_LONG;
      endcase
      return days;
   endfunction

endpackage

/* hdl/cct_leap.sv */
// Gregorian leap year test on a 16-bit year.
// Depends on cct_pkg (widths and divide-by-25 constants).
module cct_leap (
   input  logic [cct_pkg::YEAR_W-1:0] year,
   output logic                       leap
);
   import cct_pkg::*;

   logic [2*YEAR_W-1:0] prod;
   logic                div25;

   // Test divisibility by 25 with one multiply by the inverse of 25
   assign prod  = year * INV25;
   assign div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);

   // Multiple of 4, and either not a century or a multiple of 400 (16 * 25)
   assign leap = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

endmodule

/* hdl/cct_advance.sv */
// Next calendar state for one transaction: load, or a one-second tick with
// carries through minutes, hours, day, weekday, month and year.
// Depends on cct_pkg (types, limits, month length table).
module cct_advance (
   input  cct_pkg::cal_type cur,
   input  logic             cur_leap,
   input  cct_pkg::req_type req,
   output cct_pkg::cal_type nxt
);
   import cct_pkg::*;

   logic [SEC_W:0]     sec_inc;
   logic [MIN_W:0]     min_inc;
   logic [HOUR_W:0]    hour_inc;
   logic [DAY_W:0]     day_inc;
   logic [WDAY_W:0]    wday_inc;
   logic [MONTH_W:0]   month_inc;
   logic               sec_wrap;
   logic               min_wrap;
   logic               hour_wrap;
   logic               month_wrap;
   logic               year_wrap;
   logic [DAY_W-1:0]   dim;
   cal_type            ticked;

   // Increment every field in parallel; carries select which ones take effect
   assign sec_inc   = {1'b0, cur.second}  + 1'b1;
   assign min_inc   = {1'b0, cur.minute}  + 1'b1;
   assign hour_inc  = {1'b0, cur.hour}    + 1'b1;
   assign day_inc   = {1'b0, cur.day}     + 1'b1;
   assign wday_inc  = {1'b0, cur.weekday} + 1'b1;
   assign month_inc = {1'b0, cur.month}   + 1'b1;

   assign dim        = month_days(cur.month, cur_leap);
   assign sec_wrap   = (sec_inc >= SEC_LIMIT);
   assign min_wrap   = sec_wrap && (min_inc >= MIN_LIMIT);
   assign hour_wrap  = min_wrap && (hour_inc >= HOUR_LIMIT);
   assign month_wrap = hour_wrap && (day_inc > {1'b0, dim});
   assign year_wrap  = month_wrap && (month_inc > MONTH_LAST);

   // Apply one tick
   always_comb begin
      ticked = cur;
      ticked.second = sec_wrap ? '0 : sec_inc[SEC_W-1:0];
      if (sec_wrap) begin
         ticked.minute = min_wrap ? '0 : min_inc[MIN_W-1:0];
      end
      if (min_wrap) begin
         ticked.hour = hour_wrap ? '0 : hour_inc[HOUR_W-1:0];
      end
      if (hour_wrap) begin
         ticked.day     = month_wrap ? EPOCH_DAY : day_inc[DAY_W-1:0];
         ticked.weekday = (wday_inc > WDAY_LAST) ? EPOCH_WDAY : wday_inc[WDAY_W-1:0];
      end
      if (month_wrap) begin
         ticked.month = year_wrap ? EPOCH_MONTH : month_inc[MONTH_W-1:0];
      end
      if (year_wrap) begin
         ticked.year = cur.year + 1'b1;
      end
   end

   // Pick load or tick
   always_comb begin
      if (req.mode == MODE_LOAD) begin
         nxt.second  = req.set_second;
         nxt.minute  = req.set_minute;
         nxt.hour    = req.set_hour;
         nxt.day     = req.set_day;
         nxt.weekday = req.set_weekday;
         nxt.month   = req.set_month;
         nxt.year    = req.set_year;
      end else begin
         nxt = ticked;
      end
   end

endmodule

/* hdl/calendar_clock_tick.sv */
// Top level of the calendar clock tick block: input register, calendar state,
// result register. Depends on cct_pkg, cct_advance and cct_leap.
//
// Real-time-clock calendar counter. Each request transaction either loads a full
// date and time (mode 1) or is a one-second tick (mode 0), and produces exactly one
// response transaction carrying the calendar fields after that request and the
// leap flag of the current year. Reset sets the epoch, 1900-01-01 00:00:00, Monday.
// Throughput is one transaction per cycle while responses are taken. A request
// accepted into the input register passes the carry chain and the leap test of the new
// year, and is written to the result register once that register is empty or drained,
// where the response is held until it is taken.
// A stalled response holds the input register, and the input stalls once both
// registers are full. The leap flag of the stored year is kept in a register beside
// the calendar state, so February's length costs no extra logic in the carry path.
// Loaded values are stored unchecked; out-of-range fields roll over at their next
// carry.
module calendar_clock_tick (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cct_pkg::rsp_type rsp_data
);
   import cct_pkg::*;

   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   cal_type cal_ff;
   cal_type cal_in;
   logic    leap_ff;
   logic    leap_in;
   logic    rsp_free;
   logic    advance;
   rsp_type rsp_data_in;

   // Handshake: result register frees up when empty or drained this cycle
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && rsp_free;
   assign req_ready = !req_valid_ff || rsp_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cct_advance u_advance (
      .cur      (cal_ff),
      .cur_leap (leap_ff),
      .req      (req_data_ff),
      .nxt      (cal_in)
   );

   cct_leap u_leap (
      .year (cal_in.year),
      .leap (leap_in)
   );

   always_comb begin
      rsp_data_in.cur_second  = cal_in.second;
      rsp_data_in.cur_minute  = cal_in.minute;
      rsp_data_in.cur_hour    = cal_in.hour;
      rsp_data_in.cur_day     = cal_in.day;
      rsp_data_in.cur_weekday = cal_in.weekday;
      rsp_data_in.cur_month   = cal_in.month;
      rsp_data_in.cur_year    = cal_in.year;
      rsp_data_in.is_leap     = leap_in;
   end

   // Input register: hold the transaction until the datapath takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         req_data_ff <= req_data;
      end
   end

   // Calendar state and leap flag: advance once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.second  <= '0;
         cal_ff.minute  <= '0;
         cal_ff.hour    <= '0;
         cal_ff.day     <= EPOCH_DAY;
         cal_ff.weekday <= EPOCH_WDAY;
         cal_ff.month   <= EPOCH_MONTH;
         cal_ff.year    <= EPOCH_YEAR;
         leap_ff        <= EPOCH_LEAP;
      end else if (advance) begin
         cal_ff  <= cal_in;
         leap_ff <= leap_in;
      end
   end

   // Result register: hold until the response transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= advance;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
